/* src/afb_pkg.sv */
// Shared constants, types and the sigmoid point table of the activation unit.
package afb_pkg;

    localparam int FRAC_BITS = 12;
    localparam int SEGMENTS  = 32;
    localparam int DATA_W    = 16;

    localparam int SEG_BITS  = $clog2(SEGMENTS);
    localparam int FR_BITS   = FRAC_BITS + 3 - SEG_BITS;
    localparam int ARG_W     = DATA_W + 1;
    localparam int TAB_W     = FRAC_BITS + 1;
    localparam int FWD_W     = TAB_W + 2;
    localparam int FAC_W     = 2 * DATA_W + 2;
    localparam int MAC_W     = FAC_W + DATA_W;
    localparam int LOC_W     = MAC_W - 2 * FRAC_BITS;
    localparam int SUM_W     = LOC_W + 1;
    localparam int ONE       = 1 << FRAC_BITS;

    typedef enum logic [2:0] {
        OP_RELU_FWD = 3'd0,
        OP_SIG_FWD  = 3'd1,
        OP_TANH_FWD = 3'd2,
        OP_RELU_BWD = 3'd3,
        OP_SIG_BWD  = 3'd4,
        OP_TANH_BWD = 3'd5
    } t_afb_op;

    typedef struct packed {
        t_afb_op                  operation;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] grad_up;
        logic signed [DATA_W-1:0] grad_acc;
    } t_afb_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     saturated;
    } t_afb_out;

    // Sigmoid at 8k/SEGMENTS for k = 0..SEGMENTS, rounded to FRAC_BITS.
    localparam logic [TAB_W-1:0] SIG_TABLE [0:SEGMENTS] = '{
        13'd2048, 13'd2303, 13'd2550, 13'd2782, 13'd2994, 13'd3184, 13'd3349,
        13'd3490, 13'd3608, 13'd3705, 13'd3785, 13'd3850, 13'd3902, 13'd3943,
        13'd3976, 13'd4002, 13'd4022, 13'd4038, 13'd4051, 13'd4061, 13'd4069,
        13'd4075, 13'd4079, 13'd4083, 13'd4086, 13'd4088, 13'd4090, 13'd4091,
        13'd4092, 13'd4093, 13'd4094, 13'd4094, 13'd4095
    };

endpackage

/* src/afb_sig_interp.sv */
// Four-stage forward path for sigmoid and tanh by table interpolation.
module afb_sig_interp
    import afb_pkg::*;
(
    input  logic                     i_clk,
    input  t_afb_op                  i_op,
    input  logic signed [DATA_W-1:0] i_value,
    output logic signed [FWD_W-1:0]  o_fwd
);

    localparam logic [31:0] RANGE = 32'(8) << FRAC_BITS;
    localparam logic [TAB_W+FR_BITS-1:0] HALF_FR = (TAB_W+FR_BITS)'(1) << (FR_BITS - 1);
    localparam logic signed [FWD_W-1:0] ONE_F = FWD_W'(ONE);

    logic [DATA_W-1:0]        w_abs;
    logic [ARG_W-1:0]         w_arg;
    logic                     w_end;
    logic                     w_tanh;
    logic [SEG_BITS-1:0]      w_seg;
    logic [SEG_BITS:0]        w_seg_nx;
    logic [TAB_W-1:0]         n1_base;
    logic [TAB_W-1:0]         n1_diff;
    logic [TAB_W-1:0]         r1_base;
    logic [TAB_W-1:0]         r1_diff;
    logic [FR_BITS-1:0]       r1_frac;
    logic                     r1_neg;
    logic                     r1_tanh;
    logic [TAB_W+FR_BITS-1:0] w_step;
    logic [TAB_W-1:0]         n2_mag;
    logic [TAB_W-1:0]         r2_mag;
    logic                     r2_neg;
    logic                     r2_tanh;
    logic signed [FWD_W-1:0]  w_s;
    logic signed [FWD_W-1:0]  n3_fwd;
    logic signed [FWD_W-1:0]  r3_fwd;
    logic                     r3_flip;
    logic signed [FWD_W-1:0]  r4_fwd;

    // Stage 1: magnitude of the argument and the two bracketing table points.
    always_comb begin
        w_tanh   = (i_op == OP_TANH_FWD);
        w_abs    = i_value[DATA_W-1] ? (~$unsigned(i_value) + 1'b1) : $unsigned(i_value);
        w_arg    = w_tanh ? {w_abs, 1'b0} : {1'b0, w_abs};
        w_end    = ({{(32-ARG_W){1'b0}}, w_arg} >= RANGE);
        w_seg    = w_arg[FR_BITS +: SEG_BITS];
        w_seg_nx = {1'b0, w_seg} + 1'b1;
        if (w_end) begin
            n1_base = SIG_TABLE[SEGMENTS];
            n1_diff = '0;
        end else begin
            n1_base = SIG_TABLE[{1'b0, w_seg}];
            n1_diff = SIG_TABLE[w_seg_nx] - SIG_TABLE[{1'b0, w_seg}];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_base <= n1_base;
        r1_diff <= n1_diff;
        r1_frac <= w_arg[FR_BITS-1:0];
        r1_neg  <= i_value[DATA_W-1];
        r1_tanh <= w_tanh;
    end

    // Stage 2: linear interpolation inside the segment, rounded to nearest.
    always_comb begin
        w_step = (TAB_W+FR_BITS)'(r1_diff) * (TAB_W+FR_BITS)'(r1_frac) + HALF_FR;
        n2_mag = r1_base + TAB_W'(w_step >> FR_BITS);
    end

    always_ff @(posedge i_clk) begin
        r2_mag  <= n2_mag;
        r2_neg  <= r1_neg;
        r2_tanh <= r1_tanh;
    end

    // Stage 3: sigmoid mirrors negative inputs; tanh is 2s - 1.
    always_comb begin
        w_s = $signed({2'b00, r2_mag});
        if (r2_tanh) begin
            n3_fwd = (w_s <<< 1) - ONE_F;
        end else if (r2_neg) begin
            n3_fwd = ONE_F - w_s;
        end else begin
            n3_fwd = w_s;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_fwd  <= n3_fwd;
        r3_flip <= r2_neg & r2_tanh;
    end

    // Stage 4: tanh is odd, so negative inputs flip the sign.
    always_ff @(posedge i_clk) begin
        r4_fwd <= r3_flip ? -r3_fwd : r3_fwd;
    end

    assign o_fwd = r4_fwd;

endmodule

/* src/afb_grad_mac.sv */
// Four-stage local-gradient path for the sigmoid and tanh backward operations.
module afb_grad_mac
    import afb_pkg::*;
(
    input  logic                     i_clk,
    input  t_afb_op                  i_op,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic signed [DATA_W-1:0] i_grad_up,
    output logic signed [LOC_W-1:0]  o_local
);

    localparam int B_W = DATA_W + 2;
    localparam logic signed [B_W-1:0]   ONE_B = B_W'(ONE);
    localparam logic signed [FAC_W-1:0] ONE_SQ = FAC_W'(1) << (2 * FRAC_BITS);
    localparam logic signed [MAC_W-1:0] HALF_SQ = MAC_W'(1) << (2 * FRAC_BITS - 1);

    logic signed [B_W-1:0]    w_b;
    logic signed [FAC_W-1:0]  r1_prod;
    logic                     r1_tanh;
    logic signed [DATA_W-1:0] r1_grad;
    logic signed [FAC_W-1:0]  r2_fac;
    logic signed [DATA_W-1:0] r2_grad;
    logic signed [MAC_W-1:0]  r3_mac;
    logic signed [MAC_W-1:0]  w_rnd;
    logic signed [LOC_W-1:0]  r4_local;

    // Stage 1: s*(1-s) for sigmoid, t*t for tanh.
    always_comb begin
        if (i_op == OP_TANH_BWD) begin
            w_b = B_W'(i_value);
        end else begin
            w_b = ONE_B - B_W'(i_value);
        end
    end

    always_ff @(posedge i_clk) begin
        r1_prod <= FAC_W'(i_value) * FAC_W'(w_b);
        r1_tanh <= (i_op == OP_TANH_BWD);
        r1_grad <= i_grad_up;
    end

    // Stage 2: derivative factor.
    always_ff @(posedge i_clk) begin
        r2_fac  <= r1_tanh ? (ONE_SQ - r1_prod) : r1_prod;
        r2_grad <= r1_grad;
    end

    // Stage 3: scale by the upstream gradient.
    always_ff @(posedge i_clk) begin
        r3_mac <= MAC_W'(r2_fac) * MAC_W'(r2_grad);
    end

    // Stage 4: drop the doubled fraction, rounding half away from zero.
    always_comb begin
        w_rnd = r3_mac + HALF_SQ - $signed({{(MAC_W-1){1'b0}}, r3_mac[MAC_W-1]});
    end

    always_ff @(posedge i_clk) begin
        r4_local <= w_rnd[2*FRAC_BITS +: LOC_W];
    end

    assign o_local = r4_local;

endmodule

/* src/activation_forward_backward_unit.sv */
// Top level of the elementwise activation unit with forward and backward operations.
//
// One element is transferred in at each rising clock edge where start is high and
// busy is low. The element carries the operation code, the value (forward input or
// saved forward output), the upstream gradient and the accumulated gradient, all
// signed Q4.12. Busy is held low: the unit is a free-running pipeline and takes a
// new element in every cycle, so throughput is one element per clock.
//
// Each element produces exactly one result, shown on o_result for a single cycle
// with o_strobe high. The pipeline depth is set by the backward path: a product,
// the derivative factor, the gradient product, rounding, and the final add with
// saturation each take a register stage. The forward table path is padded to the
// same depth.
//
// The receiver cannot hold results off, so results leave in input order with no
// buffering. Synchronous reset clears the valid bits of every stage and the
// strobe; elements in flight at reset are dropped.
module activation_forward_backward_unit
    import afb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_afb_in  i_item,
    output t_afb_out o_result,
    output logic     o_strobe
);

    localparam int DEPTH = 4;
    localparam logic signed [SUM_W-1:0] MAX_V = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] MIN_V = -SUM_W'(32768);

    logic                    w_take;
    logic [DEPTH-1:0]        r_vld;
    t_afb_in                 r_item [0:DEPTH-1];
    logic signed [FWD_W-1:0] w_fwd;
    logic signed [LOC_W-1:0] w_local;
    t_afb_in                 w_last;
    logic                    w_pos;
    logic signed [SUM_W-1:0] w_sum;
    t_afb_out                n_out;
    t_afb_out                r_out;
    logic                    r_strobe;

    assign busy   = 1'b0;
    assign w_take = start & ~busy;

    afb_sig_interp u_sig (
        .i_clk   (i_clk),
        .i_op    (i_item.operation),
        .i_value (i_item.value),
        .o_fwd   (w_fwd)
    );

    afb_grad_mac u_mac (
        .i_clk     (i_clk),
        .i_op      (i_item.operation),
        .i_value   (i_item.value),
        .i_grad_up (i_item.grad_up),
        .o_local   (w_local)
    );

    // The element itself travels alongside the arithmetic for the final stage.
    always_ff @(posedge i_clk) begin
        r_item[0] <= i_item;
        for (int k = 1; k < DEPTH; k++) begin
            r_item[k] <= r_item[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= {r_vld[DEPTH-2:0], w_take};
            r_strobe <= r_vld[DEPTH-1];
        end
    end

    // Final stage: pick the result by operation, accumulate and saturate.
    always_comb begin
        w_last = r_item[DEPTH-1];
        w_pos  = ~w_last.value[DATA_W-1] && (w_last.value != '0);
        case (w_last.operation)
            OP_RELU_FWD: begin
                w_sum = w_pos ? SUM_W'(w_last.value) : SUM_W'(0);
            end
            OP_SIG_FWD, OP_TANH_FWD: begin
                w_sum = SUM_W'(w_fwd);
            end
            OP_RELU_BWD: begin
                w_sum = w_pos ? (SUM_W'(w_last.grad_acc) + SUM_W'(w_last.grad_up))
                              : SUM_W'(w_last.grad_acc);
            end
            OP_SIG_BWD, OP_TANH_BWD: begin
                w_sum = SUM_W'(w_last.grad_acc) + SUM_W'(w_local);
            end
            default: begin
                w_sum = SUM_W'(0);
            end
        endcase

        if (w_sum > MAX_V) begin
            n_out.result    = DATA_W'(MAX_V);
            n_out.saturated = 1'b1;
        end else if (w_sum < MIN_V) begin
            n_out.result    = DATA_W'(MIN_V);
            n_out.saturated = 1'b1;
        end else begin
            n_out.result    = DATA_W'(w_sum);
            n_out.saturated = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_result = r_out;
    assign o_strobe = r_strobe;

endmodule
